// ===== src/b64c_pkg.sv =====
// Shared types, character constants and alphabet functions of the base64 codec.
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3d;
	localparam logic [7:0] NUL_CHAR = 8'h00;
	localparam logic [7:0] SPC_CHAR = 8'h20;
	localparam logic [7:0] TAB_CHAR = 8'h09;
	localparam logic [7:0] LF_CHAR  = 8'h0a;
	localparam logic [7:0] CR_CHAR  = 8'h0d;

	localparam logic [0:0] MODE_ENCODE = 1'b0;
	localparam logic [0:0] MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       msg_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       msg_end;
		logic       stopped_invalid;
	} out_item_t;

	// Work handed from the front to the back: up to four result bytes, first in the top byte
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        bare;
		logic        msg_end;
		logic        stop_inv;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sixtet_t;

	// Map a sixtet to its alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s - 6'd26};
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s - 6'd52};
		end else if (s == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

	// Turn a 24-bit group into four characters; sixtets past nchars are padded
	function automatic logic [31:0] enc_group(input logic [23:0] bits, input logic [1:0] nchars);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			if (k <= int'(nchars)) begin
				r[31 - 8*k -: 8] = enc_char(bits[23 - 6*k -: 6]);
			end else begin
				r[31 - 8*k -: 8] = PAD_CHAR;
			end
		end
		return r;
	endfunction

	// Map an alphabet character back to its sixtet
	function automatic sixtet_t dec_sixtet(input logic [7:0] c);
		sixtet_t s;
		s.ok = 1'b1;
		s.value = '0;
		if (c inside {[8'h41:8'h5a]}) begin
			s.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7a]}) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2b) begin
			s.value = 6'd62;
		end else if (c == 8'h2f) begin
			s.value = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {SPC_CHAR, TAB_CHAR, LF_CHAR, CR_CHAR};
	endfunction

endpackage

// ===== src/b64c_front.sv =====
// Front of the base64 codec: mode register, group state and per-request job building.
module b64c_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              accept,
	input  b64c_pkg::in_item_t in_data,
	output b64c_pkg::job_t    job,
	output logic              job_push
);
	import b64c_pkg::*;

	logic        mode_q;
	logic [23:0] group_bits_q;
	logic [1:0]  group_count_q;
	logic        term_q;
	logic        inv_q;

	logic [23:0] gb_n;
	logic [1:0]  gc_n;
	logic        term_n;
	logic        inv_n;

	logic [7:0]  c;
	logic        last;
	logic [2:0]  cnt;
	logic [23:0] enc_bits;
	logic [23:0] tail_bits;
	logic [23:0] dec_bits;
	sixtet_t     sx;
	logic        flush;

	assign cfg_ready = 1'b1;
	assign job_push  = accept && (job.count != 3'd0);

	// Work out the results of the request and the next group state
	always_comb begin
		c         = in_data.data_byte;
		last      = in_data.msg_last;
		job       = '0;
		gb_n      = group_bits_q;
		gc_n      = group_count_q;
		term_n    = term_q;
		inv_n     = inv_q;
		cnt       = {1'b0, group_count_q} + 3'd1;
		enc_bits  = {group_bits_q[15:0], c};
		tail_bits = (cnt == 3'd1) ? {c, 16'h0000} : {enc_bits[15:0], 8'h00};
		dec_bits  = '0;
		sx        = dec_sixtet(c);
		flush     = 1'b0;
		if (mode_q == MODE_ENCODE) begin
			if (cnt >= 3'd3) begin
				job.data  = enc_group(enc_bits, 2'd3);
				job.count = 3'd4;
				gb_n      = '0;
				gc_n      = '0;
			end else if (last) begin
				job.data  = enc_group(tail_bits, cnt[1:0]);
				job.count = 3'd4;
				gb_n      = '0;
				gc_n      = '0;
			end else begin
				gb_n = enc_bits;
				gc_n = cnt[1:0];
			end
		end else if (!term_q) begin
			if (!is_blank(c)) begin
				if (c == PAD_CHAR || c == NUL_CHAR) begin
					flush  = 1'b1;
					term_n = 1'b1;
				end else if (!sx.ok) begin
					gb_n   = '0;
					gc_n   = '0;
					inv_n  = 1'b1;
					term_n = 1'b1;
				end else begin
					dec_bits = {group_bits_q[17:0], sx.value};
					if (cnt == 3'd4) begin
						job.data  = {dec_bits, 8'h00};
						job.count = 3'd3;
						gb_n      = '0;
						gc_n      = '0;
					end else begin
						gb_n = dec_bits;
						gc_n = cnt[1:0];
					end
				end
			end
			// A message end without pad flushes like one
			if (last && !term_n) begin
				flush = 1'b1;
			end
			if (flush) begin
				case (gc_n)
					2'd2: begin
						job.data  = {gb_n[11:4], 24'h000000};
						job.count = 3'd1;
					end
					2'd3: begin
						job.data  = {gb_n[17:10], gb_n[9:2], 16'h0000};
						job.count = 3'd2;
					end
					default: begin
					end
				endcase
				gb_n = '0;
				gc_n = '0;
			end
		end
		// Close the message: bare marker if nothing else, then clear the state
		if (last) begin
			if (job.count == 3'd0) begin
				job.count = 3'd1;
				job.bare  = 1'b1;
			end
			job.msg_end  = 1'b1;
			job.stop_inv = (mode_q == MODE_DECODE) && inv_n;
			gb_n   = '0;
			gc_n   = '0;
			term_n = 1'b0;
			inv_n  = 1'b0;
		end
	end

	// Hold mode and group state; a register write abandons any message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCODE;
			group_bits_q  <= '0;
			group_count_q <= '0;
			term_q        <= 1'b0;
			inv_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q        <= cfg_data;
			group_bits_q  <= '0;
			group_count_q <= '0;
			term_q        <= 1'b0;
			inv_q         <= 1'b0;
		end else if (accept) begin
			group_bits_q  <= gb_n;
			group_count_q <= gc_n;
			term_q        <= term_n;
			inv_q         <= inv_n;
		end
	end

endmodule

// ===== src/b64c_jobq.sv =====
// Short queue of jobs between the front and the back of the base64 codec.
module b64c_jobq #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64c_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd_en,
	output logic           head_valid,
	output b64c_pkg::job_t head
);
	import b64c_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/b64c_back.sv =====
// Back of the base64 codec: splits each job into results behind an output register.
module b64c_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  b64c_pkg::job_t    head,
	output logic              deq,
	output logic              empty,
	input  logic              pop,
	output b64c_pkg::out_item_t out_data
);
	import b64c_pkg::*;

	out_item_t   out_q;
	logic        out_valid_q;
	logic [1:0]  idx_q;
	logic        load;
	logic        is_last;
	logic [31:0] shifted;
	out_item_t   res;

	assign empty    = !out_valid_q;
	assign out_data = out_q;
	assign load     = head_valid && (!out_valid_q || pop);
	assign is_last  = (({1'b0, idx_q} + 3'd1) == head.count);
	assign deq      = load && is_last;
	assign shifted  = head.data << {idx_q, 3'b000};

	// Pick the current result of the head job
	always_comb begin
		res.out_byte        = head.bare ? 8'h00 : shifted[31:24];
		res.byte_valid      = !head.bare;
		res.run_last        = is_last;
		res.msg_end         = is_last && head.msg_end;
		res.stopped_invalid = is_last && head.stop_inv;
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	// Track output occupancy and position within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/base64_codec.sv =====
// Top level of the base64 codec: front, job queue and back.
// Base64 (standard alphabet) encoder/decoder on a byte stream; the mode register picks the
// direction (0 encode, 1 decode) and any write to it abandons a message in progress. An input
// request is taken in every cycle while the job queue between front and back has room; the
// front turns each request into at most one job of up to four results. The back drains one
// result per cycle through its output register unless a result waits to be popped, so the
// output port sets the sustained rate: four characters per three bytes when encoding, three
// bytes per four characters when decoding. The first result of a request passes through
// the job queue and then the output register. Write the mode only when the block is idle.
module base64_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                push,
	output logic                full,
	input  b64c_pkg::in_item_t  in_data,
	output logic                empty,
	input  logic                pop,
	output b64c_pkg::out_item_t out_data
);
	import b64c_pkg::*;

	job_t job;
	logic job_push;
	logic q_full;
	logic head_valid;
	job_t head;
	logic deq;
	logic accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	b64c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_data   (in_data),
		.job       (job),
		.job_push  (job_push)
	);

	b64c_jobq #(
		.DEPTH (QUEUE_DEPTH)
	) u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_push),
		.wr_job     (job),
		.full       (q_full),
		.rd_en      (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	b64c_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.out_data   (out_data)
	);

endmodule

// ===== src/b64c_checker.sv =====
// Port-level checks of the base64 codec and their binding to the top level.
module b64c_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input b64c_pkg::out_item_t out_data
);
	import b64c_pkg::*;

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data))
		else $error("waiting result changed before pop");

	// Message end closes the run of its request
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_data.msg_end |-> out_data.run_last)
		else $error("msg_end without run_last");

	// Invalid flag only on the message end
	a_inv_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_data.stopped_invalid |-> out_data.msg_end)
		else $error("stopped_invalid away from message end");

	// A bare marker is always a zero message end
	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_data.byte_valid |-> out_data.msg_end && out_data.out_byte == 8'h00)
		else $error("bare marker malformed");

endmodule

bind base64_codec b64c_checker u_b64c_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_data (out_data)
);

// ===== bench/tb_base64_codec.sv =====
// Testbench for the base64 codec: directed and random messages in both modes, checked per result.
`timescale 1ns / 100ps

module tb_base64_codec;
	import b64c_pkg::*;

	// cycles to let the block settle after the last expected result
	localparam int SETTLE_CYCLES = 8;
	localparam int TIMEOUT_NS    = 2000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = MODE_ENCODE;
	logic      push = 1'b0;
	logic      full;
	in_item_t  in_data = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t out_data;

	// codec state as predicted by the bench
	logic [0:0]  cur_mode;
	logic [23:0] grp_bits;
	logic [1:0]  grp_cnt;
	logic        grp_term;
	logic        grp_invalid;

	out_item_t expected_results[$];
	out_item_t step_results[$];
	int        error_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	base64_codec dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Alphabet character of a sixtet
	function automatic logic [7:0] sixtet_char(input logic [5:0] s);
		if (s < 26)
			return "A" + {2'b00, s};
		if (s < 52)
			return "a" + {2'b00, s} - 8'd26;
		if (s < 62)
			return "0" + {2'b00, s} - 8'd52;
		if (s == 62)
			return "+";
		return "/";
	endfunction

	// Sixtet of an alphabet character, -1 outside the alphabet
	function automatic int char_sixtet(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return int'(c - "A");
		if (c >= "a" && c <= "z")
			return int'(c - "a") + 26;
		if (c >= "0" && c <= "9")
			return int'(c - "0") + 52;
		if (c == "+")
			return 62;
		if (c == "/")
			return 63;
		return -1;
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == SPC_CHAR || c == TAB_CHAR || c == LF_CHAR || c == CR_CHAR;
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_cnt = '0;
		grp_term = 1'b0;
		grp_invalid = 1'b0;
	endfunction

	function automatic void add_result(input logic [7:0] b, input logic valid);
		out_item_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = valid;
		step_results.push_back(r);
	endfunction

	// Four characters of a group; sixtets past nchars become padding
	function automatic void add_chars(input logic [23:0] bits, input int nchars);
		for (int k = 0; k < 4; k++) begin
			if (k <= nchars)
				add_result(sixtet_char(bits[23 - 6*k -: 6]), 1'b1);
			else
				add_result(PAD_CHAR, 1'b1);
		end
	endfunction

	// Flush a partial decode group of two or three sixtets
	function automatic void flush_sixtets();
		if (grp_cnt == 2'd2) begin
			add_result(grp_bits[11:4], 1'b1);
		end else if (grp_cnt == 2'd3) begin
			add_result(grp_bits[17:10], 1'b1);
			add_result(grp_bits[9:2], 1'b1);
		end
		grp_bits = '0;
		grp_cnt = '0;
	endfunction

	// Work out the results of one accepted request and queue them
	function automatic void predict_request(input in_item_t req);
		logic [7:0] c;
		int         cnt;
		int         s;
		int         last_idx;
		c = req.data_byte;
		step_results.delete();
		if (cur_mode == MODE_ENCODE) begin
			cnt = int'(grp_cnt) + 1;
			grp_bits = {grp_bits[15:0], c};
			if (cnt == 3) begin
				add_chars(grp_bits, 3);
				grp_bits = '0;
				cnt = 0;
			end else if (req.msg_last) begin
				add_chars(grp_bits << (8 * (3 - cnt)), cnt);
				grp_bits = '0;
				cnt = 0;
			end
			grp_cnt = cnt[1:0];
		end else if (!grp_term) begin
			s = char_sixtet(c);
			if (is_space(c)) begin
				// skip white space
			end else if (c == PAD_CHAR || c == NUL_CHAR) begin
				flush_sixtets();
				grp_term = 1'b1;
			end else if (s < 0) begin
				grp_bits = '0;
				grp_cnt = '0;
				grp_invalid = 1'b1;
				grp_term = 1'b1;
			end else begin
				cnt = int'(grp_cnt) + 1;
				grp_bits = {grp_bits[17:0], s[5:0]};
				if (cnt == 4) begin
					add_result(grp_bits[23:16], 1'b1);
					add_result(grp_bits[15:8], 1'b1);
					add_result(grp_bits[7:0], 1'b1);
					grp_bits = '0;
					cnt = 0;
				end
				grp_cnt = cnt[1:0];
			end
			if (req.msg_last && !grp_term)
				flush_sixtets();
		end
		// close the message with a marker on its final result
		if (req.msg_last) begin
			if (step_results.size() == 0)
				add_result(8'h00, 1'b0);
			last_idx = step_results.size() - 1;
			step_results[last_idx].msg_end = 1'b1;
			step_results[last_idx].stopped_invalid =
				(cur_mode == MODE_DECODE) ? grp_invalid : 1'b0;
			clear_group();
		end
		if (step_results.size() > 0) begin
			last_idx = step_results.size() - 1;
			step_results[last_idx].run_last = 1'b1;
		end
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	// Drive one request, hold it until accepted, then predict its results
	task automatic send_request(input logic [7:0] b, input logic last);
		in_item_t req;
		req.data_byte = b;
		req.msg_last = last;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (full);
		predict_request(req);
	endtask

	task automatic send_text(input string txt, input logic last_at_end);
		for (int i = 0; i < txt.len(); i++)
			send_request(txt[i], last_at_end && (i == txt.len() - 1));
	endtask

	// Hold off until every expected result has come and the block has settled
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
		clear_group();
	endtask

	// Check each popped result against the oldest expectation; drive pop at random
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", out_data));
			end else begin
				want = expected_results.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, want %h",
						out_data.out_byte, want.out_byte));
				if (out_data.byte_valid !== want.byte_valid)
					report_mismatch($sformatf("byte_valid %b, want %b",
						out_data.byte_valid, want.byte_valid));
				if (out_data.run_last !== want.run_last)
					report_mismatch($sformatf("run_last %b, want %b",
						out_data.run_last, want.run_last));
				if (out_data.msg_end !== want.msg_end)
					report_mismatch($sformatf("msg_end %b, want %b",
						out_data.msg_end, want.msg_end));
				if (out_data.stopped_invalid !== want.stopped_invalid)
					report_mismatch($sformatf("stopped_invalid %b, want %b",
						out_data.stopped_invalid, want.stopped_invalid));
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Full groups, one- and two-byte tails, extreme bytes and sixtets 62 and 63
	task automatic test_encode_directed();
		send_request(8'hfb, 1'b0);
		send_request(8'hef, 1'b0);
		send_request(8'hbe, 1'b1);
		send_request(8'hff, 1'b1);
		send_request(8'h00, 1'b0);
		send_request(8'h00, 1'b1);
	endtask

	// Padding, NUL end, blanks, end without padding, lone sixtet, invalid character
	task automatic test_decode_directed();
		write_mode(MODE_DECODE);
		send_text("//8=", 1'b1);
		send_text("Zg", 1'b0);
		send_request(NUL_CHAR, 1'b1);
		send_text("Q\tU J\r\n", 1'b1);
		send_text("A", 1'b1);
		send_text("Z!g=", 1'b1);
		send_text("+/+/", 1'b1);
	endtask

	// A mode write drops a partial group and clears a stop on an invalid character
	task automatic test_mode_write_abandons();
		write_mode(MODE_ENCODE);
		send_request(8'h41, 1'b0);
		send_request(8'h42, 1'b0);
		write_mode(MODE_ENCODE);
		send_request(8'h43, 1'b1);
		write_mode(MODE_DECODE);
		send_text("Zm!", 1'b0);
		write_mode(MODE_DECODE);
		send_text("QQ", 1'b1);
	endtask

	task automatic send_encode_message(output int n_items);
		n_items = $urandom_range(10, 1);
		for (int i = 0; i < n_items; i++)
			send_request(8'($urandom_range(255)), i == n_items - 1);
	endtask

	// Mostly well-formed text with random content; the rest noise and broken text
	task automatic send_decode_message(output int n_items);
		logic [7:0]  raw[$];
		logic [7:0]  text[$];
		logic [7:0]  c;
		logic [23:0] g;
		int          kind;
		int          nraw;
		int          nch;
		int          pos;
		kind = $urandom_range(9);
		nraw = $urandom_range(8, 1);
		for (int i = 0; i < nraw; i++)
			raw.push_back(8'($urandom_range(255)));
		for (int i = 0; i < nraw; i += 3) begin
			nch = (nraw - i >= 3) ? 3 : nraw - i;
			g = {raw[i], (i + 1 < nraw) ? raw[i + 1] : 8'h00,
				(i + 2 < nraw) ? raw[i + 2] : 8'h00};
			for (int k = 0; k < 4; k++) begin
				if (k <= nch)
					text.push_back(sixtet_char(g[23 - 6*k -: 6]));
				else if (kind <= 3 || kind == 7)
					text.push_back(PAD_CHAR);
			end
		end
		case (kind)
			6: begin
				text.push_back(NUL_CHAR);
			end
			7: begin
				do c = 8'($urandom_range(255));
				while (char_sixtet(c) >= 0 || is_space(c) || c == PAD_CHAR || c == NUL_CHAR);
				pos = $urandom_range(text.size() - 1);
				text[pos] = c;
			end
			8: begin
				text.delete();
				repeat ($urandom_range(6, 1))
					text.push_back(8'($urandom_range(255)));
			end
			9: begin
				text.push_back(sixtet_char(6'($urandom_range(63))));
			end
			default: ;
		endcase
		// trailing characters land after termination where the text ended early
		if (kind == 0 || kind == 6 || kind == 7) begin
			repeat ($urandom_range(3, 1))
				text.push_back(sixtet_char(6'($urandom_range(63))));
		end
		n_items = 0;
		for (int i = 0; i < text.size(); i++) begin
			if ($urandom_range(5) == 0) begin
				case ($urandom_range(3))
					0: c = SPC_CHAR;
					1: c = TAB_CHAR;
					2: c = LF_CHAR;
					default: c = CR_CHAR;
				endcase
				send_request(c, 1'b0);
				n_items++;
			end
			send_request(text[i], i == text.size() - 1);
			n_items++;
		end
	endtask

	task automatic test_random_messages();
		int done;
		int n;
		done = 0;
		write_mode(MODE_ENCODE);
		while (done < 20) begin
			send_encode_message(n);
			done += n;
		end
		done = 0;
		write_mode(MODE_DECODE);
		while (done < 20) begin
			send_decode_message(n);
			done += n;
		end
	endtask

	initial begin
		cur_mode = MODE_ENCODE;
		clear_group();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 34;
		recv_idle_pct = 73;
		test_encode_directed();
		test_decode_directed();
		test_mode_write_abandons();
		test_random_messages();
		send_idle_pct = 73;
		recv_idle_pct = 34;
		test_random_messages();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages();
		wait_drained();
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
